// File: src/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants of the positional list engine: request and
// status codes, the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package plist_pkg;

   // list geometry
   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int POS_W       = 5;
   localparam int TYPE_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request type codes on the input channel
   localparam logic [TYPE_W-1:0] REQ_INS_FRONT = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INS_POS   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INS_BACK  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_DELETE    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_SEARCH    = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_LIST      = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

   // operation carried out by the back end
   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_DELETE,
      CMD_SEARCH,
      CMD_LIST
   } cmd_op_type;

   // where an insert lands
   typedef enum logic [1:0] {
      WHERE_FRONT,
      WHERE_POS,
      WHERE_BACK
   } ins_where_type;

   // classified request
   typedef struct packed {
      cmd_op_type             op;
      ins_where_type          where;
      logic [POS_W-1:0]       position;
      logic [VALUE_WIDTH-1:0] value;
   } cmd_type;

endpackage

// File: src/plist_front.sv
// ----------------------------------------------------------------------------
// plist_front
// Front end: takes requests, drops unknown request types and turns the rest
// into command words for the queue.
// ----------------------------------------------------------------------------
module plist_front
   import plist_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TYPE_W-1:0]      req_type,
   input  logic [POS_W-1:0]       req_position,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   push,
   output cmd_type                push_cmd,
   input  logic                   queue_ready
);

   logic known;

   // request decoder
   always_comb begin
      known          = 1'b1;
      push_cmd.op    = CMD_INSERT;
      push_cmd.where = WHERE_POS;
      unique case (req_type)
         REQ_INS_FRONT: begin
            push_cmd.where = WHERE_FRONT;
         end
         REQ_INS_POS: begin
            push_cmd.where = WHERE_POS;
         end
         REQ_INS_BACK: begin
            push_cmd.where = WHERE_BACK;
         end
         REQ_DELETE: begin
            push_cmd.op = CMD_DELETE;
         end
         REQ_SEARCH: begin
            push_cmd.op = CMD_SEARCH;
         end
         REQ_LIST: begin
            push_cmd.op = CMD_LIST;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      push_cmd.position = req_position;
      push_cmd.value    = req_value;
   end

   // unknown types are taken and dropped; known ones wait for queue space
   // ready is held low while reset is applied
   assign req_ready = !reset && (queue_ready || !known);
   assign push      = req_valid && queue_ready && known && !reset;

endmodule

// File: src/plist_queue.sv
// ----------------------------------------------------------------------------
// plist_queue
// Short command queue between the front end and the back end, so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module plist_queue
   import plist_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    queue_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff;
   logic [QCNT_W-1:0]   fill_in;
   logic                do_push;
   logic                do_pop;

   assign queue_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid   = (fill_ff != '0);
   assign pop_cmd     = slot_ff[rd_ptr_ff];
   assign do_push     = push && queue_ready;
   assign do_pop      = pop && pop_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // command storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/plist_back.sv
// ----------------------------------------------------------------------------
// plist_back
// Back end: holds the list, does inserts and deletes from the idle state,
// and scans one position a cycle for search/list unless the result stalls.
// ----------------------------------------------------------------------------
module plist_back
   import plist_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  cmd_type                pop_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [VALUE_WIDTH-1:0] rsp_item_value,
   output logic [IDX_W-1:0]       rsp_item_position,
   output logic [COUNT_W-1:0]     rsp_length,
   output logic                   rsp_last
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_SCAN = 2'b10
   } back_state_type;

   back_state_type         state_ff;
   back_state_type         state_in;
   logic [VALUE_WIDTH-1:0] entry_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] entry_in [CAPACITY];
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_in;
   logic [CAPACITY-1:0]    mask_ff;
   logic [CAPACITY-1:0]    mask_in;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       idx_in;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [STATUS_W-1:0]    out_status_ff;
   logic [STATUS_W-1:0]    out_status_in;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic [VALUE_WIDTH-1:0] out_value_in;
   logic [IDX_W-1:0]       out_pos_ff;
   logic [IDX_W-1:0]       out_pos_in;
   logic [COUNT_W-1:0]     out_length_ff;
   logic [COUNT_W-1:0]     out_length_in;
   logic                   out_last_ff;
   logic                   out_last_in;

   logic                   out_free;
   logic [POS_W-1:0]       ins_pos;
   logic [POS_W-1:0]       count_pos;
   logic                   is_full;
   logic                   is_empty;
   logic [CAPACITY-1:0]    live_mask;
   logic [CAPACITY-1:0]    hit_mask;
   logic [CAPACITY-1:0]    rest_mask;
   logic                   do_insert;
   logic                   do_delete;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign pop       = pop_valid && (state_ff == BK_IDLE) && out_free;
   assign count_pos = POS_W'(count_ff);
   assign is_full   = (count_ff == COUNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign rest_mask = mask_ff & ~(CAPACITY'(1) << idx_ff);

   // resolved insert position
   always_comb begin
      case (pop_cmd.where)
         WHERE_FRONT: ins_pos = '0;
         WHERE_BACK:  ins_pos = count_pos;
         default:     ins_pos = pop_cmd.position;
      endcase
   end

   // occupied positions and search matches, compared in parallel
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         live_mask[k] = (COUNT_W'(k) < count_ff);
         hit_mask[k]  = live_mask[k] && (entry_ff[k] == pop_cmd.value);
      end
   end

   // sequencer and result register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_pos_in    = out_pos_ff;
      out_length_in = out_length_ff;
      out_last_in   = out_last_ff;
      do_insert     = 1'b0;
      do_delete     = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               out_value_in = '0;
               out_pos_in   = '0;
               out_last_in  = 1'b1;
               out_status_in = ST_OK;
               case (pop_cmd.op)
                  CMD_INSERT: begin
                     out_valid_in = 1'b1;
                     if (is_full) begin
                        out_status_in = ST_OVERFLOW;
                     end else if (ins_pos > count_pos) begin
                        out_status_in = ST_BADPOS;
                     end else begin
                        do_insert = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     out_valid_in = 1'b1;
                     if (is_empty) begin
                        out_status_in = ST_UNDERFLOW;
                     end else if (pop_cmd.position >= count_pos) begin
                        out_status_in = ST_BADPOS;
                     end else begin
                        do_delete = 1'b1;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     if (hit_mask == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_NOTFOUND;
                     end else begin
                        mask_in  = hit_mask;
                        idx_in   = '0;
                        state_in = BK_SCAN;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_UNDERFLOW;
                     end else begin
                        mask_in  = live_mask;
                        idx_in   = '0;
                        state_in = BK_SCAN;
                     end
                  end
               endcase
               out_length_in = count_in;
            end
         end
         BK_SCAN: begin
            if (out_free) begin
               if (mask_ff[idx_ff]) begin
                  out_valid_in  = 1'b1;
                  out_status_in = ST_OK;
                  out_value_in  = entry_ff[idx_ff];
                  out_pos_in    = idx_ff;
                  out_length_in = count_ff;
                  out_last_in   = (rest_mask == '0);
                  mask_in       = rest_mask;
                  if (rest_mask == '0) begin
                     state_in = BK_IDLE;
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // entry shift network: insert moves the tail up, delete moves it down
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         entry_in[k] = entry_ff[k];
         if (do_insert) begin
            if (POS_W'(k) == ins_pos) begin
               entry_in[k] = pop_cmd.value;
            end else if ((k > 0) && (POS_W'(k) > ins_pos)) begin
               entry_in[k] = entry_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (do_delete) begin
            if ((k < CAPACITY - 1) && (POS_W'(k) >= pop_cmd.position)) begin
               entry_in[k] = entry_ff[(k < CAPACITY - 1) ? k + 1 : k];
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mask_ff       <= mask_in;
      idx_ff        <= idx_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_pos_ff    <= out_pos_in;
      out_length_ff <= out_length_in;
      out_last_ff   <= out_last_in;
      for (int k = 0; k < CAPACITY; k++) begin
         entry_ff[k] <= entry_in[k];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_item_value    = out_value_ff;
   assign rsp_item_position = out_pos_ff;
   assign rsp_length        = out_length_ff;
   assign rsp_last          = out_last_ff;

endmodule

// File: src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to 16 values with insert, delete, search and list
// requests; a decoding front end and an executing back end meet at a queue.
//
//   channel   direction  ports                                    handshake
//   request   in         req_type, req_position, req_value        req_valid/ready
//   result    out        rsp_status, rsp_item_value,              rsp_valid/ready
//                        rsp_item_position, rsp_length, rsp_last
//
// inserts and deletes: carried out from the back end idle state, one result
// search and list: the back end starts a scan, then walks one position of
//   the list a cycle while the result side does not stall, up to 16 positions
// the two-entry queue keeps taking requests, until it is full, while the
//   back end works or the result waits
// reset is synchronous and empties the list; stalls on the result side hold
//   the scan in place
// ----------------------------------------------------------------------------
module positional_list_engine
   import plist_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TYPE_W-1:0]      req_type,
   input  logic [POS_W-1:0]       req_position,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [VALUE_WIDTH-1:0] rsp_item_value,
   output logic [IDX_W-1:0]       rsp_item_position,
   output logic [COUNT_W-1:0]     rsp_length,
   output logic                   rsp_last
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_ready;
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop;

   // request decode
   plist_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_position (req_position),
      .req_value    (req_value),
      .push         (push),
      .push_cmd     (push_cmd),
      .queue_ready  (queue_ready)
   );

   // command queue
   plist_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_cmd    (push_cmd),
      .queue_ready (queue_ready),
      .pop_valid   (pop_valid),
      .pop_cmd     (pop_cmd),
      .pop         (pop)
   );

   // list storage and execution
   plist_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_cmd           (pop_cmd),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_item_value    (rsp_item_value),
      .rsp_item_position (rsp_item_position),
      .rsp_length        (rsp_length),
      .rsp_last          (rsp_last)
   );

endmodule
